### hw/rtl/rk4dv_pkg.sv
// rk4dv_pkg: types, constants and helper functions shared by the RK4 damped
// velocity step block. No dependencies.
package rk4dv_pkg;

    localparam int FRACTION_BITS = 24;
    localparam int WORD_W        = 32;
    localparam int DT_W          = 24;
    localparam int COEF_W        = 24;
    localparam int DT_FRAC       = 24;
    localparam int COEF_FRAC     = 16;
    localparam int PROD_W        = DT_W + 1 + WORD_W;
    localparam int WIDE_W        = 64;
    localparam int SUM_W         = 36;
    localparam int INDEX_W       = 8;
    localparam int DIGIT_W       = 6;
    localparam int DIGITS        = SUM_W / DIGIT_W;
    localparam int DIV_CNT_W     = 3;

    // 1.0 in state format, clamped when it does not fit
    localparam logic signed [WORD_W-1:0] ONE_RAW =
        (FRACTION_BITS >= 31) ? 32'sh7FFF_FFFF : WORD_W'(64'd1 << FRACTION_BITS);

    localparam logic [DT_W-1:0]            STEP_SIZE_RST = 24'd167772;
    localparam logic [COEF_W-1:0]          RATE_COEF_RST = 24'd3276800;
    localparam logic signed [WORD_W-1:0]   INIT_VEL_RST  = '0;

    // divide-by-six bias: n + 3*2^34 keeps the dividend non-negative
    localparam logic [SUM_W-1:0] DIV_OFFSET = 36'hC_0000_0000;
    localparam logic [SUM_W-1:0] DIV_BIAS   = 36'h4_0000_0000;

    localparam logic signed [WIDE_W-1:0] S32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [WIDE_W-1:0] S32_MIN = 64'shFFFF_FFFF_8000_0000;

    typedef enum logic [INDEX_W-1:0] {
        REG_STEP_SIZE = 8'd0,
        REG_RATE_COEF = 8'd1,
        REG_INIT_POS  = 8'd2,
        REG_INIT_VEL  = 8'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_F,
        ST_MUL_X,
        ST_MUL_V,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINAL,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_F,
        MUL_X,
        MUL_V
    } mul_op_t;

    typedef struct packed {
        mul_op_t           op;
        logic [DT_W-1:0]   a;
        logic [WORD_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        mul_op_t           op;
        logic [WORD_W-1:0] value;
        logic              sat;
    } mul_rsp_t;

    typedef struct packed {
        logic              start;
        logic [SUM_W-1:0]  sx;
        logic [SUM_W-1:0]  sv;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] qx;
        logic [WORD_W-1:0] qv;
    } div_rsp_t;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              flag;
    } sat_t;

    function automatic sat_t sat32(input logic signed [WIDE_W-1:0] a);
        sat_t r;
        if (a > S32_MAX)
        begin
            r.value = S32_MAX[WORD_W-1:0];
            r.flag  = 1'b1;
        end
        else if (a < S32_MIN)
        begin
            r.value = S32_MIN[WORD_W-1:0];
            r.flag  = 1'b1;
        end
        else
        begin
            r.value = a[WORD_W-1:0];
            r.flag  = 1'b0;
        end
        return r;
    endfunction

    function automatic logic signed [WIDE_W-1:0] sext32(input logic [WORD_W-1:0] v);
        return $signed({{(WIDE_W-WORD_W){v[WORD_W-1]}}, v});
    endfunction

endpackage

### hw/rtl/rk4dv_if.sv
// rk4dv_if: valid/ready channel interfaces for the request, result and
// configuration beats. Depends on rk4dv_pkg.
interface rk4dv_req_if;
    logic valid;
    logic ready;
    logic restart;
    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

interface rk4dv_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [rk4dv_pkg::WORD_W-1:0] position_out;
    logic signed [rk4dv_pkg::WORD_W-1:0] velocity_out;
    logic                              saturated;
    modport source (output valid, output position_out, output velocity_out,
                    output saturated, input ready);
    modport sink   (input valid, input position_out, input velocity_out,
                    input saturated, output ready);
endinterface

interface rk4dv_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [rk4dv_pkg::INDEX_W-1:0]    index;
    logic [rk4dv_pkg::WORD_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/rk4_damped_velocity_step.sv
// rk4_damped_velocity_step: one RK4 step of x' = v, v' = -c*v per request beat.
// A step beat runs 4 stages x 4 slots on the shared multiplier (slope, position
// and velocity products, update), then the divide by six and the final state
// update; a restart beat skips the arithmetic and goes straight to the output.
// Throughput: one beat at a time; a new request is taken once the result is
// handed to the output register, which waits while a result sits unaccepted.
// Reset loads the register defaults, position 1.0.
module rk4_damped_velocity_step
(
    input  logic               clk,
    input  logic               rst_n,
    rk4dv_req_if.sink          req,
    rk4dv_rsp_if.source        rsp,
    rk4dv_cfg_if.sink          cfg
);

    rk4dv_pkg::state_t                   state_reg, state_next;
    logic [rk4dv_pkg::DT_W-1:0]          step_size_reg;
    logic [rk4dv_pkg::COEF_W-1:0]        rate_coef_reg;
    logic [rk4dv_pkg::WORD_W-1:0]        init_pos_reg, init_vel_reg;
    logic [rk4dv_pkg::WORD_W-1:0]        position_reg, velocity_reg;
    logic [rk4dv_pkg::WORD_W-1:0]        w_reg, f_reg;
    logic [rk4dv_pkg::WORD_W-1:0]        qx_reg, qv_reg;
    logic [rk4dv_pkg::SUM_W-1:0]         sx_reg, sv_reg;
    logic [1:0]                          stage_reg;
    logic                                sat_reg;
    logic                                out_valid_reg;
    logic [rk4dv_pkg::WORD_W-1:0]        out_pos_reg, out_vel_reg;
    logic                                out_sat_reg;

    rk4dv_pkg::mul_req_t                 mreq;
    rk4dv_pkg::mul_rsp_t                 mrsp;
    rk4dv_pkg::div_req_t                 dreq;
    rk4dv_pkg::div_rsp_t                 drsp;

    logic                                accept;
    logic                                out_free;
    logic                                doubled;
    logic [rk4dv_pkg::SUM_W-1:0]         term;
    logic [rk4dv_pkg::WORD_W-1:0]        kv_step;
    rk4dv_pkg::sat_t                     w_sat, pos_sat, vel_sat;

    rk4dv_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    rk4dv_div6 u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == rk4dv_pkg::ST_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !out_valid_reg || rsp.ready;

    assign rsp.valid        = out_valid_reg;
    assign rsp.position_out = out_pos_reg;
    assign rsp.velocity_out = out_vel_reg;
    assign rsp.saturated    = out_sat_reg;

    // stages two and three carry weight two in the final sums
    assign doubled = (stage_reg == 2'd1) || (stage_reg == 2'd2);
    assign term    = doubled ? {{(rk4dv_pkg::SUM_W-rk4dv_pkg::WORD_W-1){mrsp.value[31]}},
                                mrsp.value, 1'b0}
                             : {{(rk4dv_pkg::SUM_W-rk4dv_pkg::WORD_W){mrsp.value[31]}},
                                mrsp.value};
    // next midpoint velocity: half the slope for stages one and two, full for three
    assign kv_step = (stage_reg == 2'd2) ? mrsp.value
                                         : {mrsp.value[31], mrsp.value[31:1]};
    assign w_sat   = rk4dv_pkg::sat32(rk4dv_pkg::sext32(velocity_reg)
                                      + rk4dv_pkg::sext32(kv_step));
    assign pos_sat = rk4dv_pkg::sat32(rk4dv_pkg::sext32(position_reg)
                                      + rk4dv_pkg::sext32(qx_reg));
    assign vel_sat = rk4dv_pkg::sat32(rk4dv_pkg::sext32(velocity_reg)
                                      + rk4dv_pkg::sext32(qv_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rk4dv_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mreq.op    = rk4dv_pkg::MUL_NONE;
        mreq.a     = step_size_reg;
        mreq.b     = w_reg;
        dreq.start = 1'b0;
        dreq.sx    = sx_reg;
        dreq.sv    = sv_reg;
        unique case (state_reg)
            rk4dv_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = req.restart ? rk4dv_pkg::ST_OUT : rk4dv_pkg::ST_MUL_F;
            end
            rk4dv_pkg::ST_MUL_F:
            begin
                mreq.op    = rk4dv_pkg::MUL_F;
                mreq.a     = rate_coef_reg;
                state_next = rk4dv_pkg::ST_MUL_X;
            end
            rk4dv_pkg::ST_MUL_X:
            begin
                mreq.op    = rk4dv_pkg::MUL_X;
                state_next = rk4dv_pkg::ST_MUL_V;
            end
            rk4dv_pkg::ST_MUL_V:
            begin
                mreq.op    = rk4dv_pkg::MUL_V;
                mreq.b     = f_reg;
                state_next = rk4dv_pkg::ST_UPDATE;
            end
            rk4dv_pkg::ST_UPDATE:
            begin
                state_next = (stage_reg == 2'd3) ? rk4dv_pkg::ST_DIV_GO
                                                 : rk4dv_pkg::ST_MUL_F;
            end
            rk4dv_pkg::ST_DIV_GO:
            begin
                dreq.start = 1'b1;
                state_next = rk4dv_pkg::ST_DIV_WAIT;
            end
            rk4dv_pkg::ST_DIV_WAIT:
            begin
                if (drsp.done)
                    state_next = rk4dv_pkg::ST_FINAL;
            end
            rk4dv_pkg::ST_FINAL:
            begin
                state_next = rk4dv_pkg::ST_OUT;
            end
            rk4dv_pkg::ST_OUT:
            begin
                if (out_free)
                    state_next = rk4dv_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rk4dv_pkg::ST_IDLE;
            end
        endcase
    end

    // configuration and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg <= rk4dv_pkg::STEP_SIZE_RST;
            rate_coef_reg <= rk4dv_pkg::RATE_COEF_RST;
            init_pos_reg  <= rk4dv_pkg::ONE_RAW;
            init_vel_reg  <= rk4dv_pkg::INIT_VEL_RST;
            position_reg  <= rk4dv_pkg::ONE_RAW;
            velocity_reg  <= rk4dv_pkg::INIT_VEL_RST;
            sat_reg       <= 1'b0;
            stage_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    rk4dv_pkg::REG_STEP_SIZE: step_size_reg <= cfg.data[rk4dv_pkg::DT_W-1:0];
                    rk4dv_pkg::REG_RATE_COEF: rate_coef_reg <= cfg.data[rk4dv_pkg::COEF_W-1:0];
                    rk4dv_pkg::REG_INIT_POS:  init_pos_reg  <= cfg.data;
                    rk4dv_pkg::REG_INIT_VEL:  init_vel_reg  <= cfg.data;
                    default: ;
                endcase
            end

            if (accept)
            begin
                sat_reg   <= 1'b0;
                stage_reg <= 2'd0;
                if (req.restart)
                begin
                    position_reg <= init_pos_reg;
                    velocity_reg <= init_vel_reg;
                end
            end
            else
            begin
                if (mrsp.sat)
                    sat_reg <= 1'b1;
                if (state_reg == rk4dv_pkg::ST_UPDATE)
                begin
                    stage_reg <= stage_reg + 1'b1;
                    if (stage_reg != 2'd3 && w_sat.flag)
                        sat_reg <= 1'b1;
                end
                if (state_reg == rk4dv_pkg::ST_FINAL)
                begin
                    position_reg <= pos_sat.value;
                    velocity_reg <= vel_sat.value;
                    if (pos_sat.flag || vel_sat.flag)
                        sat_reg <= 1'b1;
                end
            end

            if (state_reg == rk4dv_pkg::ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // working registers of one step
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            w_reg  <= velocity_reg;
            sx_reg <= '0;
            sv_reg <= '0;
        end
        else
        begin
            unique case (mrsp.op)
                rk4dv_pkg::MUL_F: f_reg  <= mrsp.value;
                rk4dv_pkg::MUL_X: sx_reg <= sx_reg + term;
                rk4dv_pkg::MUL_V: sv_reg <= sv_reg + term;
                default: ;
            endcase
            if (state_reg == rk4dv_pkg::ST_UPDATE)
                w_reg <= w_sat.value;
        end
        if (state_reg == rk4dv_pkg::ST_DIV_WAIT && drsp.done)
        begin
            qx_reg <= drsp.qx;
            qv_reg <= drsp.qv;
        end
        if (state_reg == rk4dv_pkg::ST_OUT && out_free)
        begin
            out_pos_reg <= position_reg;
            out_vel_reg <= velocity_reg;
            out_sat_reg <= sat_reg;
        end
    end

endmodule

### hw/rtl/rk4dv_mul.sv
// rk4dv_mul: shared 25x32 signed multiplier with registered product and
// scaling/saturation on the way out. Depends on rk4dv_pkg.
module rk4dv_mul
(
    input  logic                clk,
    input  logic                rst_n,
    input  rk4dv_pkg::mul_req_t req,
    output rk4dv_pkg::mul_rsp_t rsp
);

    rk4dv_pkg::mul_op_t                       op_reg;
    logic signed [rk4dv_pkg::PROD_W-1:0]      prod_reg;
    logic signed [rk4dv_pkg::PROD_W-1:0]      prod_next;
    logic signed [rk4dv_pkg::WIDE_W-1:0]      p64;
    logic signed [rk4dv_pkg::WIDE_W-1:0]      scaled;
    rk4dv_pkg::sat_t                          s;

    assign prod_next = $signed({1'b0, req.a}) * $signed(req.b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= rk4dv_pkg::MUL_NONE;
        end
        else
        begin
            op_reg <= req.op;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_comb
    begin
        p64 = {{(rk4dv_pkg::WIDE_W-rk4dv_pkg::PROD_W){prod_reg[rk4dv_pkg::PROD_W-1]}},
               prod_reg};
        // derivative term is the negated, floored coefficient product
        if (op_reg == rk4dv_pkg::MUL_F)
            scaled = -(p64 >>> rk4dv_pkg::COEF_FRAC);
        else
            scaled = p64 >>> rk4dv_pkg::DT_FRAC;
        s = rk4dv_pkg::sat32(scaled);
        rsp.op    = op_reg;
        rsp.value = s.value;
        rsp.sat   = s.flag && (op_reg != rk4dv_pkg::MUL_NONE);
    end

endmodule

### hw/rtl/rk4dv_div6.sv
// rk4dv_div6: floor division of two signed sums by six, one radix-64 digit
// per cycle for both lanes. Depends on rk4dv_pkg.
module rk4dv_div6
(
    input  logic                clk,
    input  logic                rst_n,
    input  rk4dv_pkg::div_req_t req,
    output rk4dv_pkg::div_rsp_t rsp
);

    logic                                  busy_reg;
    logic                                  done_reg;
    logic [rk4dv_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [rk4dv_pkg::SUM_W-1:0]           mx_reg, mv_reg;
    logic [rk4dv_pkg::SUM_W-1:0]           qx_reg, qv_reg;
    logic [1:0]                            rx_reg, rv_reg;
    logic [rk4dv_pkg::SUM_W-1:0]           mx_init, mv_init;
    logic [rk4dv_pkg::DIGIT_W+1:0]         stx, stv;
    logic [rk4dv_pkg::SUM_W-1:0]           qx_fix, qv_fix;

    // one digit of a divide by three: {quotient digit, remainder}
    function automatic logic [rk4dv_pkg::DIGIT_W+1:0] div3_step(
        input logic [1:0]                    rem,
        input logic [rk4dv_pkg::DIGIT_W-1:0] dig);
        logic [7:0]  val;
        logic [15:0] pq;
        logic [5:0]  qd;
        logic [7:0]  r;
        val = {rem, dig};
        pq  = {8'd0, val} * 16'd171;   // 171/512 ~ 1/3, exact for val < 192
        qd  = pq[14:9];
        r   = val - {1'b0, qd, 1'b0} - {2'd0, qd};
        return {qd, r[1:0]};
    endfunction

    // floor(s/6) = floor(floor(s/2)/3); add 3*2^34 so the dividend is positive
    assign mx_init = {req.sx[rk4dv_pkg::SUM_W-1], req.sx[rk4dv_pkg::SUM_W-1:1]}
                     + rk4dv_pkg::DIV_OFFSET;
    assign mv_init = {req.sv[rk4dv_pkg::SUM_W-1], req.sv[rk4dv_pkg::SUM_W-1:1]}
                     + rk4dv_pkg::DIV_OFFSET;

    assign stx = div3_step(rx_reg, mx_reg[rk4dv_pkg::SUM_W-1 -: rk4dv_pkg::DIGIT_W]);
    assign stv = div3_step(rv_reg, mv_reg[rk4dv_pkg::SUM_W-1 -: rk4dv_pkg::DIGIT_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == rk4dv_pkg::DIV_CNT_W'(rk4dv_pkg::DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mx_reg <= mx_init;
            mv_reg <= mv_init;
            rx_reg <= 2'd0;
            rv_reg <= 2'd0;
        end
        else if (busy_reg)
        begin
            mx_reg <= mx_reg << rk4dv_pkg::DIGIT_W;
            mv_reg <= mv_reg << rk4dv_pkg::DIGIT_W;
            qx_reg <= {qx_reg[rk4dv_pkg::SUM_W-rk4dv_pkg::DIGIT_W-1:0],
                       stx[rk4dv_pkg::DIGIT_W+1:2]};
            qv_reg <= {qv_reg[rk4dv_pkg::SUM_W-rk4dv_pkg::DIGIT_W-1:0],
                       stv[rk4dv_pkg::DIGIT_W+1:2]};
            rx_reg <= stx[1:0];
            rv_reg <= stv[1:0];
        end
    end

    assign qx_fix   = qx_reg - rk4dv_pkg::DIV_BIAS;
    assign qv_fix   = qv_reg - rk4dv_pkg::DIV_BIAS;
    assign rsp.done = done_reg;
    assign rsp.qx   = qx_fix[rk4dv_pkg::WORD_W-1:0];
    assign rsp.qv   = qv_fix[rk4dv_pkg::WORD_W-1:0];

endmodule

### test/rk4dv_step_checker.sv
// rk4dv_step_checker: watches the request, result and configuration channels,
// predicts every result with its own fixed-point RK4 step and compares beats.
// Depends on rk4dv_pkg and the channel interfaces of rk4dv_if.
module rk4dv_step_checker
(
    input  logic  clk,
    input  logic  rst_n,
    rk4dv_req_if  req_mon,
    rk4dv_rsp_if  rsp_mon,
    rk4dv_cfg_if  cfg_mon,
    output int    mismatches,
    output int    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import rk4dv_pkg::*;

    typedef struct packed {
        logic signed [WORD_W-1:0] position;
        logic signed [WORD_W-1:0] velocity;
        logic                     saturated;
    } rk4_state_t;

    rk4_state_t expected_states[$];

    logic [DT_W-1:0]          dt_q;
    logic [COEF_W-1:0]        coef_q;
    logic signed [WORD_W-1:0] init_pos_q;
    logic signed [WORD_W-1:0] init_vel_q;
    logic signed [WORD_W-1:0] pos_q;
    logic signed [WORD_W-1:0] vel_q;
    logic                     clamp_hit;
    int                       error_total;

    function automatic logic signed [WORD_W-1:0] clamp_word(input longint a);
        if (a > S32_MAX)
        begin
            clamp_hit = 1'b1;
            return S32_MAX[WORD_W-1:0];
        end
        if (a < S32_MIN)
        begin
            clamp_hit = 1'b1;
            return S32_MIN[WORD_W-1:0];
        end
        return a[WORD_W-1:0];
    endfunction

    // arithmetic shift of a signed 64-bit product is a floor
    function automatic logic signed [WORD_W-1:0] scale_by_dt(input logic signed [WORD_W-1:0] w);
        return clamp_word((longint'(dt_q) * longint'(w)) >>> DT_FRAC);
    endfunction

    function automatic logic signed [WORD_W-1:0] damping_rate(input logic signed [WORD_W-1:0] w);
        return clamp_word(-((longint'(coef_q) * longint'(w)) >>> COEF_FRAC));
    endfunction

    function automatic longint floor_sixth(input longint a);
        longint q;
        q = a / 6;
        if ((a % 6 != 0) && (a < 0))
            q = q - 1;
        return q;
    endfunction

    task automatic advance_rk4(input logic reload, output rk4_state_t next);
        logic signed [WORD_W-1:0] v, v2, v3, v4;
        logic signed [WORD_W-1:0] k1x, k1v, k2x, k2v, k3x, k3v, k4x, k4v;
        longint sx, sv;
        clamp_hit = 1'b0;
        if (reload)
        begin
            pos_q = init_pos_q;
            vel_q = init_vel_q;
        end
        else
        begin
            v   = vel_q;
            k1x = scale_by_dt(v);
            k1v = scale_by_dt(damping_rate(v));
            v2  = clamp_word(longint'(v) + (longint'(k1v) >>> 1));
            k2x = scale_by_dt(v2);
            k2v = scale_by_dt(damping_rate(v2));
            v3  = clamp_word(longint'(v) + (longint'(k2v) >>> 1));
            k3x = scale_by_dt(v3);
            k3v = scale_by_dt(damping_rate(v3));
            v4  = clamp_word(longint'(v) + longint'(k3v));
            k4x = scale_by_dt(v4);
            k4v = scale_by_dt(damping_rate(v4));
            sx  = longint'(k1x) + 2 * longint'(k2x) + 2 * longint'(k3x) + longint'(k4x);
            sv  = longint'(k1v) + 2 * longint'(k2v) + 2 * longint'(k3v) + longint'(k4v);
            pos_q = clamp_word(longint'(pos_q) + floor_sixth(sx));
            vel_q = clamp_word(longint'(v) + floor_sixth(sv));
        end
        next.position  = pos_q;
        next.velocity  = vel_q;
        next.saturated = clamp_hit;
    endtask

    task automatic report_field(input string field, input logic signed [WORD_W-1:0] want,
                                input logic signed [WORD_W-1:0] got);
        error_total++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        rk4_state_t want;
        rk4_state_t got;
        if (!rst_n)
        begin
            dt_q        = STEP_SIZE_RST;
            coef_q      = RATE_COEF_RST;
            init_pos_q  = ONE_RAW;
            init_vel_q  = INIT_VEL_RST;
            pos_q       = ONE_RAW;
            vel_q       = INIT_VEL_RST;
            error_total = 0;
            expected_states.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_mon.valid && cfg_mon.ready)
            begin
                case (cfg_mon.index)
                    REG_STEP_SIZE: dt_q       = cfg_mon.data[DT_W-1:0];
                    REG_RATE_COEF: coef_q     = cfg_mon.data[COEF_W-1:0];
                    REG_INIT_POS:  init_pos_q = cfg_mon.data;
                    REG_INIT_VEL:  init_vel_q = cfg_mon.data;
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready)
            begin
                advance_rk4(req_mon.restart, want);
                expected_states.push_back(want);
            end
            if (rsp_mon.valid && rsp_mon.ready)
            begin
                got.position  = rsp_mon.position_out;
                got.velocity  = rsp_mon.velocity_out;
                got.saturated = rsp_mon.saturated;
                if (expected_states.size() == 0)
                begin
                    error_total++;
                    $display("%0t: result beat with none expected, position %0d, velocity %0d",
                             $time, got.position, got.velocity);
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (got.position !== want.position)
                        report_field("position_out", want.position, got.position);
                    if (got.velocity !== want.velocity)
                        report_field("velocity_out", want.velocity, got.velocity);
                    if (got.saturated !== want.saturated)
                        report_field("saturated", {31'b0, want.saturated},
                                     {31'b0, got.saturated});
                end
            end
            mismatches  <= error_total;
            outstanding <= expected_states.size();
        end
    end

endmodule

### test/tb_rk4_damped_velocity_step.sv
// tb_rk4_damped_velocity_step: drives request and configuration beats with
// bursty timing and a stalling result sink, then reports the verdict.
// Depends on rk4dv_pkg, rk4dv_if, rk4dv_step_checker and the block itself.
module tb_rk4_damped_velocity_step;
    timeunit 1ns;
    timeprecision 1ps;

    import rk4dv_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 3;
    localparam int RANDOM_ITEMS     = 1450;
    localparam int PRESSURE_PHASE   = 2;
    localparam int LONG_HOLD        = 400;
    localparam int DRAIN_CYCLES     = 40;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int RESTART_PCT      = 5;
    localparam int FIRST_FREE_INDEX = int'(REG_INIT_VEL) + 1;
    localparam int LAST_INDEX       = (1 << INDEX_W) - 1;

    localparam logic [WORD_W-1:0] WORD_MAX     = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [WORD_W-1:0] MINUS_ONE    = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] FULL24       = 32'h00FF_FFFF;
    localparam logic [WORD_W-1:0] COEF_ONE     = 32'h0001_0000;
    localparam logic [WORD_W-1:0] DT_HUNDREDTH = 32'h0002_8F5C;

    typedef enum int {
        SINK_OPEN,
        SINK_COIN,
        SINK_SPARSE,
        SINK_MOSTLY
    } sink_mode_t;

    logic clk          = 1'b0;
    logic rst_n        = 1'b0;
    logic hold_request = 1'b0;
    logic no_gaps      = 1'b0;
    int   burst_left   = 0;
    int   mismatches;
    int   outstanding;

    rk4dv_req_if req_if();
    rk4dv_rsp_if rsp_if();
    rk4dv_cfg_if cfg_if();

    rk4_damped_velocity_step u_top
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    rk4dv_step_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_mon     (req_if),
        .rsp_mon     (rsp_if),
        .cfg_mon     (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // 24-bit registers get noise in the unused upper byte
    function automatic logic [WORD_W-1:0] pick_frac24();
        logic [23:0] v;
        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = '1;
            2, 3, 4: v = 24'($urandom);
            default: v = 24'($urandom_range(0, 1 << 20));
        endcase
        return {8'($urandom), v};
    endfunction

    function automatic logic [WORD_W-1:0] pick_state_word();
        case ($urandom_range(0, 9))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3, 4:    return $urandom;
            default: return 32'($urandom_range(0, 1 << 27) - (1 << 26));
        endcase
    endfunction

    task automatic offer_req(input logic reload);
        int gap;
        req_if.valid   <= 1'b1;
        req_if.restart <= reload;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = no_gaps ? 0 : $urandom_range(0, 40);
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // leaves valid high so back-to-back writes keep one assignment per step
    task automatic put_reg(input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
    endtask

    task automatic drain_results();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_phase(input logic [WORD_W-1:0] dt_word, input logic [WORD_W-1:0] coef_word,
                             input logic [WORD_W-1:0] pos_word, input logic [WORD_W-1:0] vel_word,
                             input logic lead_restart, input int n_items, input int restart_pct);
        put_reg(REG_STEP_SIZE, dt_word);
        put_reg(REG_RATE_COEF, coef_word);
        put_reg(REG_INIT_POS, pos_word);
        put_reg(REG_INIT_VEL, vel_word);
        // unmapped index, must leave every register alone
        put_reg(INDEX_W'($urandom_range(FIRST_FREE_INDEX, LAST_INDEX)), $urandom);
        cfg_if.valid <= 1'b0;
        for (int i = 0; i < n_items; i++)
            offer_req((i == 0) ? lead_restart : ($urandom_range(1, 100) <= restart_pct));
        drain_results();
    endtask

    initial
    begin : result_sink
        sink_mode_t mode;
        int span;
        int hold;
        mode = SINK_OPEN;
        span = 0;
        hold = 0;
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold = LONG_HOLD;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (span == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 3));
                    span = $urandom_range(20, 200);
                end
                span--;
                case (mode)
                    SINK_OPEN:   rsp_if.ready <= 1'b1;
                    SINK_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
                    SINK_SPARSE: rsp_if.ready <= ($urandom_range(0, 7) == 0);
                    default:     rsp_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
            @(posedge clk);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int sent;
        int phase;
        int n;
        req_if.valid   <= 1'b0;
        req_if.restart <= 1'b0;
        cfg_if.valid   <= 1'b0;
        cfg_if.index   <= '0;
        cfg_if.data    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults and reset state
        offer_req(1'b0);
        offer_req(1'b1);
        offer_req(1'b0);
        drain_results();

        // ordinary decay from x = 1, v = 1
        run_phase(DT_HUNDREDTH, {8'hA5, 24'd3276800}, ONE_RAW, ONE_RAW, 1'b1, 4, 0);
        // everything at full scale: slopes and state clamp
        run_phase(MINUS_ONE, MINUS_ONE, WORD_MAX, WORD_MAX, 1'b1, 3, 0);
        // no damping, largest step: position runs into the negative rail
        run_phase(FULL24, '0, WORD_MIN, WORD_MIN, 1'b1, 3, 0);
        // zero step: state holds but the slope itself clamps
        run_phase('0, FULL24, WORD_MAX, WORD_MAX, 1'b1, 3, 0);
        // small negative velocity, floor rounding
        run_phase(FULL24, FULL24, '0, MINUS_ONE, 1'b1, 3, 0);
        // unit damping on the most negative velocity: negation overflows
        run_phase(FULL24, COEF_ONE, '0, WORD_MIN, 1'b1, 3, 0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            n = $urandom_range(10, 120);
            if (phase == PRESSURE_PHASE)
            begin
                // sink stalls for a long stretch while requests keep coming
                hold_request = 1'b1;
                no_gaps      = 1'b1;
            end
            run_phase(pick_frac24(), pick_frac24(), pick_state_word(), pick_state_word(),
                      $urandom_range(0, 4) != 0, n, RESTART_PCT);
            no_gaps = 1'b0;
            sent += n;
            phase++;
        end

        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
